>>> hw/rtl/ogsu_pkg.sv
package ogsu_pkg;

  // Defaults for the top-level parameters.
  localparam int GRID_SIDE_DEF       = 32;
  localparam int BORDER_VALUE_DEF    = 40;
  localparam int BACK_FAR_ONE_MM_DEF = 1800;
  localparam int BACK_FAR_TWO_MM_DEF = 2400;

  // Fixed properties of the evidence grid.
  localparam int BORDER_CELLS = 4;
  localparam int CLASS_LIMIT  = 20;
  localparam int CELL_W       = 16;
  localparam int WEIGHT_W     = 8;
  localparam int RANGE_W      = 16;
  localparam int POS_W        = 5;

  // Stream payload widths.
  localparam int S_DATA_W = 144;
  localparam int M_DATA_W = 24;

  // Configuration port.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [2:0] REG_BAND_ONE  = 3'd0;
  localparam logic [2:0] REG_BAND_TWO  = 3'd1;
  localparam logic [2:0] REG_BAND_THR  = 3'd2;
  localparam logic [2:0] REG_BAND_FOUR = 3'd3;
  localparam logic [2:0] REG_MARGIN    = 3'd4;
  localparam logic [2:0] REG_OCC_WT    = 3'd5;
  localparam logic [2:0] REG_FREE_WT   = 3'd6;
  localparam logic [2:0] REG_HERE_WT   = 3'd7;

  // Item kinds on s_tuser.
  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Cell classes.
  localparam logic [1:0] CLASS_UNKNOWN  = 2'd0;
  localparam logic [1:0] CLASS_FREE     = 2'd1;
  localparam logic [1:0] CLASS_OCCUPIED = 2'd2;

  // Body directions, in the order they are processed.
  localparam logic [1:0] DIR_FRONT = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_BACK  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // Compass headings.
  localparam logic [1:0] HEAD_NORTH = 2'd0;
  localparam logic [1:0] HEAD_EAST  = 2'd1;
  localparam logic [1:0] HEAD_SOUTH = 2'd2;
  localparam logic [1:0] HEAD_WEST  = 2'd3;

  // Band indexes.
  localparam logic [1:0] BAND_ONE   = 2'd0;
  localparam logic [1:0] BAND_TWO   = 2'd1;
  localparam logic [1:0] BAND_THREE = 2'd2;
  localparam logic [1:0] BAND_FOUR  = 2'd3;

endpackage

>>> hw/rtl/occupancy_grid_sonar_update_core.sv
// Channel   Role    Handshake              Payload
// s_*       input   s_tvalid / s_tready    s_tdata: pose, heading, ranges; s_tuser: kind
// m_*       output  m_tvalid / m_tready    m_tdata: cell_value, cell_class, saturated
// apb       config  psel / penable / pready  8 registers at byte address 4*i
//
// A scan makes up to 17 cell updates, each a read step and a write step through the one
// shared read-modify-write adder, after a setup step and before a final cell read and result.
// A read item makes only the final cell read and the result. Cell updates run one after
// another over the single memory read port. After reset a clearing pass writes the grid while
// s_tready stays low. A result still waiting on m_tready holds the next item in its last step.
module occupancy_grid_sonar_update_core
  import ogsu_pkg::*;
#(
  parameter int GRID_SIDE       = GRID_SIDE_DEF,
  parameter int BORDER_VALUE    = BORDER_VALUE_DEF,
  parameter int BACK_FAR_ONE_MM = BACK_FAR_ONE_MM_DEF,
  parameter int BACK_FAR_TWO_MM = BACK_FAR_TWO_MM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // pos_x[4:0], pos_y[9:5], heading[11:10], front_range_a[27:12],
  // front_range_b[43:28], right_range_a[59:44], right_range_b[75:60],
  // back_range_a[91:76], back_range_b[107:92], left_range_a[123:108],
  // left_range_b[139:124], zero fill[143:140]
  input  logic [S_DATA_W-1:0]   s_tdata,
  // kind[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // cell_value[15:0], cell_class[17:16], saturated[18], zero fill[23:19]
  output logic [M_DATA_W-1:0]   m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W     = $clog2(GRID_SIDE);
  localparam int MEM_DEPTH = 1 << (2 * IDX_W);
  localparam int XW        = ((IDX_W > POS_W) ? IDX_W : POS_W) + 2;

  localparam logic [IDX_W-1:0]        IDX_LAST = IDX_W'(GRID_SIDE - 1);
  localparam logic [IDX_W-1:0]        EDGE_LO  = IDX_W'(BORDER_CELLS);
  localparam logic [IDX_W-1:0]        EDGE_HI  = IDX_W'(GRID_SIDE - 1 - BORDER_CELLS);
  localparam logic signed [XW-1:0]    SIDE_S   = XW'(GRID_SIDE);
  localparam logic signed [CELL_W-1:0] BORDER_CELL = CELL_W'(BORDER_VALUE);
  localparam logic [RANGE_W-1:0]      BACK_ONE = RANGE_W'(BACK_FAR_ONE_MM);
  localparam logic [RANGE_W-1:0]      BACK_TWO = RANGE_W'(BACK_FAR_TWO_MM);
  localparam logic signed [CELL_W-1:0] LIMIT_POS = CELL_W'(CLASS_LIMIT);
  localparam logic signed [CELL_W-1:0] LIMIT_NEG = -CELL_W'(CLASS_LIMIT);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SETUP  = 7'b0000100,
    ST_RD     = 7'b0001000,
    ST_WR     = 7'b0010000,
    ST_LOOK   = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [RANGE_W-1:0]      band_one_range;
  logic [RANGE_W-1:0]      band_two_range;
  logic [RANGE_W-1:0]      band_three_range;
  logic [RANGE_W-1:0]      band_four_range;
  logic [RANGE_W-1:0]      side_margin;
  logic [31:0]             occupied_weights;
  logic [31:0]             free_weights;
  logic [WEIGHT_W-1:0]     here_free_weight;

  // Captured item.
  logic                    kind;
  logic [POS_W-1:0]        pos_x;
  logic [POS_W-1:0]        pos_y;
  logic [1:0]              heading;
  logic [RANGE_W-1:0]      rng_a [4];
  logic [RANGE_W-1:0]      rng_b [4];

  // Sequencer state.
  logic                    wall;
  logic [1:0]              cur_dir;
  logic [1:0]              cur_band;
  logic                    scan_done;
  logic                    sat;
  logic [IDX_W-1:0]        clr_x;
  logic [IDX_W-1:0]        clr_y;

  // Pending update.
  logic [2*IDX_W-1:0]      addr;
  logic                    upd_on;
  logic signed [WEIGHT_W-1:0] weight;

  // Memory.
  logic signed [CELL_W-1:0] mem [MEM_DEPTH];
  logic signed [CELL_W-1:0] rdata;
  logic                     we;
  logic [2*IDX_W-1:0]       waddr;
  logic signed [CELL_W-1:0] wdata;

  // Output register.
  logic signed [CELL_W-1:0] out_value;
  logic [1:0]               out_class;
  logic                     out_sat;

  // ---------------------------------------------------------------------------
  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_one_range   <= 16'd600;
      band_two_range   <= 16'd1200;
      band_three_range <= 16'd1800;
      band_four_range  <= 16'd2400;
      side_margin      <= '0;
      occupied_weights <= '0;
      free_weights     <= '0;
      here_free_weight <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_BAND_ONE:  band_one_range   <= pwdata[RANGE_W-1:0];
        REG_BAND_TWO:  band_two_range   <= pwdata[RANGE_W-1:0];
        REG_BAND_THR:  band_three_range <= pwdata[RANGE_W-1:0];
        REG_BAND_FOUR: band_four_range  <= pwdata[RANGE_W-1:0];
        REG_MARGIN:    side_margin      <= pwdata[RANGE_W-1:0];
        REG_OCC_WT:    occupied_weights <= pwdata;
        REG_FREE_WT:   free_weights     <= pwdata;
        REG_HERE_WT:   here_free_weight <= pwdata[WEIGHT_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_BAND_ONE:  prdata = APB_DATA_W'(band_one_range);
      REG_BAND_TWO:  prdata = APB_DATA_W'(band_two_range);
      REG_BAND_THR:  prdata = APB_DATA_W'(band_three_range);
      REG_BAND_FOUR: prdata = APB_DATA_W'(band_four_range);
      REG_MARGIN:    prdata = APB_DATA_W'(side_margin);
      REG_OCC_WT:    prdata = occupied_weights;
      REG_FREE_WT:   prdata = free_weights;
      REG_HERE_WT:   prdata = APB_DATA_W'(here_free_weight);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Wall check: any side reading below the widened band one threshold.
  logic [RANGE_W:0] side_near;
  logic             wall_now;

  assign side_near = {1'b0, band_one_range} + {1'b0, side_margin};
  assign wall_now  = ({1'b0, rng_a[DIR_RIGHT]} < side_near) ||
                     ({1'b0, rng_b[DIR_RIGHT]} < side_near) ||
                     ({1'b0, rng_a[DIR_LEFT]}  < side_near) ||
                     ({1'b0, rng_b[DIR_LEFT]}  < side_near);

  // ---------------------------------------------------------------------------
  // Band planner: threshold, hit test and target cell for (cur_dir, cur_band).
  logic [RANGE_W-1:0]       th_base;
  logic [RANGE_W:0]         th;
  logic                     hit;
  logic                     end_dir;
  logic [1:0]               adir;
  logic signed [XW-1:0]     robot_x;
  logic signed [XW-1:0]     robot_y;
  logic signed [XW-1:0]     step;
  logic signed [XW-1:0]     tgt_x;
  logic signed [XW-1:0]     tgt_y;
  logic                     tgt_on;
  logic                     robot_on;
  logic signed [WEIGHT_W-1:0] plan_weight;

  assign robot_x  = signed'(XW'(pos_x));
  assign robot_y  = signed'(XW'(pos_y));
  assign robot_on = (robot_x < SIDE_S) && (robot_y < SIDE_S);

  always_comb begin
    case (cur_band)
      BAND_ONE:   th_base = band_one_range;
      BAND_TWO:   th_base = band_two_range;
      BAND_THREE: th_base = (cur_dir == DIR_BACK) ? BACK_ONE : band_three_range;
      default:    th_base = (cur_dir == DIR_BACK) ? BACK_TWO : band_four_range;
    endcase
  end

  assign th  = {1'b0, th_base} + (cur_dir[0] ? {1'b0, side_margin} : '0);
  assign hit = ({1'b0, rng_a[cur_dir]} < th) || ({1'b0, rng_b[cur_dir]} < th);
  assign end_dir = hit || (cur_band == BAND_FOUR) || (wall && !cur_dir[0]);

  assign plan_weight = hit ? occupied_weights[{cur_band, 3'b000} +: WEIGHT_W]
                           : free_weights[{cur_band, 3'b000} +: WEIGHT_W];

  assign adir = heading + cur_dir;
  assign step = signed'(XW'({1'b0, cur_band} + 3'd1));

  always_comb begin
    tgt_x = robot_x;
    tgt_y = robot_y;
    case (adir)
      HEAD_NORTH: tgt_y = robot_y - step;
      HEAD_EAST:  tgt_x = robot_x + step;
      HEAD_SOUTH: tgt_y = robot_y + step;
      HEAD_WEST:  tgt_x = robot_x - step;
      default:    ;
    endcase
  end

  assign tgt_on = (tgt_x >= 0) && (tgt_x < SIDE_S) && (tgt_y >= 0) && (tgt_y < SIDE_S);

  // ---------------------------------------------------------------------------
  // Shared saturating adder for the read-modify-write of one cell.
  logic signed [CELL_W:0] sum;
  logic                   sum_ovf;
  logic signed [CELL_W-1:0] sum_sat;

  assign sum     = (CELL_W + 1)'(rdata) + (CELL_W + 1)'(weight);
  assign sum_ovf = sum[CELL_W] != sum[CELL_W-1];

  always_comb begin
    if (!sum_ovf) begin
      sum_sat = sum[CELL_W-1:0];
    end else if (sum[CELL_W]) begin
      sum_sat = {1'b1, {(CELL_W - 1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(CELL_W - 1){1'b1}}};
    end
  end

  // ---------------------------------------------------------------------------
  // Memory write selection: clearing pass or cell update.
  logic clr_border;

  assign clr_border = (clr_x < EDGE_LO) || (clr_x > EDGE_HI) ||
                      (clr_y < EDGE_LO) || (clr_y > EDGE_HI);

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = sum_sat;
    if (state == ST_CLEAR) begin
      we    = 1'b1;
      waddr = {clr_y, clr_x};
      wdata = clr_border ? BORDER_CELL : '0;
    end else if (state == ST_WR) begin
      we = upd_on;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[addr];
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  logic s_fire;
  logic out_load;

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_load = (state == ST_RESULT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_x     <= '0;
      clr_y     <= '0;
      m_tvalid  <= 1'b0;
      sat       <= 1'b0;
      scan_done <= 1'b0;
      cur_dir   <= DIR_FRONT;
      cur_band  <= BAND_ONE;
      wall      <= 1'b0;
      upd_on    <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (clr_x == IDX_LAST) begin
            clr_x <= '0;
            clr_y <= clr_y + 1'b1;
            if (clr_y == IDX_LAST) begin
              state <= ST_IDLE;
            end
          end else begin
            clr_x <= clr_x + 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_fire) begin
            sat   <= 1'b0;
            state <= (s_tuser == KIND_READ) ? ST_LOOK : ST_SETUP;
          end
        end
        ST_SETUP: begin
          // Robot cell first, then the direction bands.
          wall      <= wall_now;
          upd_on    <= robot_on;
          cur_dir   <= DIR_FRONT;
          cur_band  <= BAND_ONE;
          scan_done <= 1'b0;
          state     <= ST_RD;
        end
        ST_RD: begin
          state <= ST_WR;
        end
        ST_WR: begin
          if (upd_on && sum_ovf) begin
            sat <= 1'b1;
          end
          if (scan_done) begin
            state <= ST_LOOK;
          end else begin
            upd_on <= tgt_on;
            if (end_dir) begin
              cur_dir   <= cur_dir + 1'b1;
              cur_band  <= BAND_ONE;
              scan_done <= (cur_dir == DIR_LEFT);
            end else begin
              cur_band <= cur_band + 1'b1;
            end
            state <= ST_RD;
          end
        end
        ST_LOOK: begin
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item capture, update address and weight, result payload.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_fire) begin
          kind    <= s_tuser;
          pos_x   <= s_tdata[4:0];
          pos_y   <= s_tdata[9:5];
          heading <= s_tdata[11:10];
          for (int d = 0; d < 4; d++) begin
            rng_a[d] <= s_tdata[12 + 32*d +: RANGE_W];
            rng_b[d] <= s_tdata[28 + 32*d +: RANGE_W];
          end
          addr <= {IDX_W'(s_tdata[9:5]), IDX_W'(s_tdata[4:0])};
        end
      end
      ST_SETUP: begin
        addr   <= {robot_y[IDX_W-1:0], robot_x[IDX_W-1:0]};
        weight <= signed'(here_free_weight);
      end
      ST_WR: begin
        if (scan_done) begin
          addr <= {robot_y[IDX_W-1:0], robot_x[IDX_W-1:0]};
        end else begin
          addr   <= {tgt_y[IDX_W-1:0], tgt_x[IDX_W-1:0]};
          weight <= plan_weight;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          out_value <= robot_on ? rdata : '0;
          out_sat   <= (kind == KIND_SCAN) && sat;
          if (robot_on && (rdata > LIMIT_POS)) begin
            out_class <= CLASS_OCCUPIED;
          end else if (robot_on && (rdata < LIMIT_NEG)) begin
            out_class <= CLASS_FREE;
          end else begin
            out_class <= CLASS_UNKNOWN;
          end
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {5'b0, out_sat, out_class, out_value};

endmodule

>>> hw/rtl/ogsu_checker.sv
module ogsu_checker
  import ogsu_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  localparam logic signed [CELL_W-1:0] LIMIT_POS = CELL_W'(CLASS_LIMIT);
  localparam logic signed [CELL_W-1:0] LIMIT_NEG = -CELL_W'(CLASS_LIMIT);

  // A result that is not taken stays put.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // One item at a time: the input closes right after a transaction.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input open again right after a transaction");

  // The grid clearing pass keeps the input closed after reset.
  assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input open right after reset");

  // The class agrees with the reported value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[17:16] == CLASS_OCCUPIED) |-> signed'(m_tdata[15:0]) > LIMIT_POS)
    else $error("occupied class with a low value");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[17:16] == CLASS_FREE) |-> signed'(m_tdata[15:0]) < LIMIT_NEG)
    else $error("free class with a high value");

endmodule

bind occupancy_grid_sonar_update_core ogsu_checker u_ogsu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
